FILE: hw/rtl/cialu_pkg.sv
// Shared types and constants for the complex integer ALU.
// No dependencies.
`default_nettype none
package cialu_pkg;
  localparam int unsigned OperandWidth = 16;
  localparam int unsigned ResWidth = 33;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  typedef enum logic {
    StatOk = 1'b0,
    StatDivZero = 1'b1
  } status_e;
endpackage
`default_nettype wire

FILE: hw/rtl/cialu_if.sv
// Valid/ready stream channels for the complex integer ALU.
// Depends on cialu_pkg.
`default_nettype none
interface cialu_in_if #(
  parameter int unsigned OW = cialu_pkg::OperandWidth
);
  logic valid;
  logic ready;
  logic [1:0] op;
  logic signed [OW-1:0] a_re;
  logic signed [OW-1:0] a_im;
  logic signed [OW-1:0] b_re;
  logic signed [OW-1:0] b_im;
  modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cialu_out_if;
  logic valid;
  logic ready;
  logic signed [cialu_pkg::ResWidth-1:0] res_re;
  logic signed [cialu_pkg::ResWidth-1:0] res_im;
  logic status;
  modport source (output valid, res_re, res_im, status, input ready);
  modport sink (input valid, res_re, res_im, status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/cialu_front.sv
// Front end: accepts beats, forms products, numerators and divisor.
// Depends on cialu_pkg. One registered product stage.
`default_nettype none
module cialu_front #(
  parameter int unsigned OW = cialu_pkg::OperandWidth,
  localparam int unsigned PW = 2 * OW + 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic [1:0] op_i,
  input  wire logic signed [OW-1:0] a_re_i,
  input  wire logic signed [OW-1:0] a_im_i,
  input  wire logic signed [OW-1:0] b_re_i,
  input  wire logic signed [OW-1:0] b_im_i,
  output logic fe_valid_o,
  input  wire logic fe_ready_i,
  output logic [1:0] fe_op_o,
  output logic signed [PW-1:0] fe_x_o,
  output logic signed [PW-1:0] fe_y_o,
  output logic [PW-1:0] fe_den_o
);
  logic signed [OW-1:0] ar, ai, br, bi;
  logic signed [2*OW-1:0] p_rr, p_ii, p_ir, p_ri, p_bb, p_cc;
  logic [1:0] op_q;
  logic signed [2*OW-1:0] rr_q, ii_q, ir_q, ri_q, bb_q, cc_q;
  logic signed [OW:0] sre_q, sim_q;
  logic v_q;

  assign ar = a_re_i;
  assign ai = a_im_i;
  assign br = b_re_i;
  assign bi = b_im_i;
  assign p_rr = ar * br;
  assign p_ii = ai * bi;
  assign p_ir = ai * br;
  assign p_ri = ar * bi;
  assign p_bb = br * br;
  assign p_cc = bi * bi;

  assign in_ready_o = !v_q || fe_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q <= op_i;
      rr_q <= p_rr; ii_q <= p_ii; ir_q <= p_ir; ri_q <= p_ri;
      bb_q <= p_bb; cc_q <= p_cc;
      if (cialu_pkg::op_e'(op_i) == cialu_pkg::OpAdd) begin
        sre_q <= (OW+1)'(ar) + (OW+1)'(br);
        sim_q <= (OW+1)'(ai) + (OW+1)'(bi);
      end else begin
        sre_q <= (OW+1)'(ar) - (OW+1)'(br);
        sim_q <= (OW+1)'(ai) - (OW+1)'(bi);
      end
    end
  end

  always_comb begin
    fe_valid_o = v_q;
    fe_op_o = op_q;
    fe_den_o = PW'(unsigned'(bb_q)) + PW'(unsigned'(cc_q));
    case (cialu_pkg::op_e'(op_q))
      cialu_pkg::OpMul: begin
        fe_x_o = PW'(rr_q) - PW'(ii_q);
        fe_y_o = PW'(ir_q) + PW'(ri_q);
      end
      cialu_pkg::OpDiv: begin
        fe_x_o = PW'(rr_q) + PW'(ii_q);
        fe_y_o = PW'(ir_q) - PW'(ri_q);
      end
      default: begin
        fe_x_o = PW'(sre_q);
        fe_y_o = PW'(sim_q);
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/cialu_queue.sv
// Two-entry FIFO decoupling front and back ends.
// No dependencies.
`default_nettype none
module cialu_queue #(
  parameter int unsigned W = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic [W-1:0] in_data_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic [W-1:0] out_data_o
);
  logic [W-1:0] mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count slip");
endmodule
`default_nettype wire

FILE: hw/rtl/cialu_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage, both lanes.
// Depends on cialu_pkg.
`default_nettype none
module cialu_back #(
  parameter int unsigned OW = cialu_pkg::OperandWidth,
  localparam int unsigned PW = 2 * OW + 2,
  localparam int unsigned MW = PW - 1,
  localparam int unsigned RW = cialu_pkg::ResWidth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic [1:0] op_i,
  input  wire logic signed [PW-1:0] x_i,
  input  wire logic signed [PW-1:0] y_i,
  input  wire logic [PW-1:0] den_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic signed [RW-1:0] res_re_o,
  output logic signed [RW-1:0] res_im_o,
  output logic status_o
);
  localparam int unsigned NS = MW + 1;
  typedef struct packed {
    logic div;
    logic zero;
    logic nx;
    logic ny;
    logic [PW-1:0] den;
    logic [MW-1:0] qx;
    logic [MW-1:0] qy;
    logic [PW-1:0] rx;
    logic [PW-1:0] ry;
    logic [RW-1:0] px;
    logic [RW-1:0] py;
  } stg_t;

  stg_t s_q [NS];
  logic v_q [NS];
  logic adv;
  stg_t s0;

  assign adv = !v_q[NS-1] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    s0 = '0;
    s0.div = cialu_pkg::op_e'(op_i) == cialu_pkg::OpDiv;
    s0.zero = den_i == '0;
    s0.nx = x_i[PW-1];
    s0.ny = y_i[PW-1];
    s0.den = den_i;
    s0.qx = MW'(x_i[PW-1] ? -x_i : x_i);
    s0.qy = MW'(y_i[PW-1] ? -y_i : y_i);
    s0.px = RW'(x_i);
    s0.py = RW'(y_i);
  end

  function automatic stg_t step(stg_t s);
    stg_t r;
    logic [PW-1:0] tx, ty;
    r = s;
    tx = {s.rx[PW-2:0], s.qx[MW-1]};
    ty = {s.ry[PW-2:0], s.qy[MW-1]};
    r.qx = {s.qx[MW-2:0], 1'b0};
    r.qy = {s.qy[MW-2:0], 1'b0};
    if (tx >= s.den) begin
      tx = tx - s.den;
      r.qx[0] = 1'b1;
    end
    if (ty >= s.den) begin
      ty = ty - s.den;
      r.qy[0] = 1'b1;
    end
    r.rx = tx;
    r.ry = ty;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_valid_i;
      for (int i = 1; i < NS; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q[0] <= s0;
      for (int i = 1; i < NS; i++) s_q[i] <= step(s_q[i-1]);
    end
  end

  stg_t f;
  logic [RW-1:0] mx, my;
  assign f = s_q[NS-1];
  assign mx = RW'(f.qx);
  assign my = RW'(f.qy);
  assign out_valid_o = v_q[NS-1];
  always_comb begin
    status_o = cialu_pkg::StatOk;
    if (!f.div) begin
      res_re_o = f.px;
      res_im_o = f.py;
    end else if (f.zero) begin
      res_re_o = '0;
      res_im_o = '0;
      status_o = cialu_pkg::StatDivZero;
    end else begin
      res_re_o = f.nx ? -mx : mx;
      res_im_o = f.ny ? -my : my;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (res_re_o == '0 && res_im_o == '0))
    else $error("divide-by-zero result not cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(res_re_o))
    else $error("result changed under stall");
endmodule
`default_nettype wire

FILE: hw/rtl/complex_integer_alu_top.sv
// Top level of the complex integer ALU.
// Depends on cialu_pkg, cialu_if, cialu_front, cialu_queue, cialu_back.
`default_nettype none
// Takes one beat per cycle unless back-pressure stalls it, and returns one result
// per beat, in order. A beat passes one product stage, a two-entry queue,
// then a restoring divider that resolves one quotient bit
// per stage for both components; add, subtract and multiply ride the same
// pipeline so order holds. A zero divisor returns zeros with status set.
module complex_integer_alu_top #(
  parameter int unsigned OPERAND_WIDTH = cialu_pkg::OperandWidth
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  cialu_in_if.sink in_if,
  cialu_out_if.source out_if
);
  localparam int unsigned PW = 2 * OPERAND_WIDTH + 2;
  localparam int unsigned QW = 2 + 3 * PW;

  logic fe_valid, fe_ready, be_valid, be_ready;
  logic [1:0] fe_op, be_op;
  logic signed [PW-1:0] fe_x, fe_y, be_x, be_y;
  logic [PW-1:0] fe_den, be_den;

  cialu_front #(.OW(OPERAND_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .op_i(in_if.op), .a_re_i(in_if.a_re), .a_im_i(in_if.a_im),
    .b_re_i(in_if.b_re), .b_im_i(in_if.b_im),
    .fe_valid_o(fe_valid), .fe_ready_i(fe_ready),
    .fe_op_o(fe_op), .fe_x_o(fe_x), .fe_y_o(fe_y), .fe_den_o(fe_den)
  );

  cialu_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(fe_valid), .in_ready_o(fe_ready),
    .in_data_i({fe_op, fe_x, fe_y, fe_den}),
    .out_valid_o(be_valid), .out_ready_i(be_ready),
    .out_data_o({be_op, be_x, be_y, be_den})
  );

  cialu_back #(.OW(OPERAND_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(be_valid), .in_ready_o(be_ready),
    .op_i(be_op), .x_i(be_x), .y_i(be_y), .den_i(be_den),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .res_re_o(out_if.res_re), .res_im_o(out_if.res_im), .status_o(out_if.status)
  );
endmodule
`default_nettype wire

FILE: tb/complex_integer_alu_top_tb.sv
// Self-checking bench for complex_integer_alu_top: random and corner operand beats,
// expected results computed in-bench and checked in order.
// Depends on cialu_pkg, cialu_if and the RTL.
module complex_integer_alu_top_tb;
  localparam int unsigned OW = cialu_pkg::OperandWidth;
  localparam int unsigned RW = cialu_pkg::ResWidth;
  localparam int Latency = 2 * OW + 4;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic signed [RW-1:0] re;
    logic signed [RW-1:0] im;
    cialu_pkg::status_e st;
  } cplx_res_t;

  int errors = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  class cplx_scoreboard;
    cplx_res_t pending[$];

    function automatic cplx_res_t compute(cialu_pkg::op_e op, logic signed [OW-1:0] ar,
        logic signed [OW-1:0] ai, logic signed [OW-1:0] br, logic signed [OW-1:0] bi);
      cplx_res_t r;
      longint nre, nim, den, qre, qim;
      r = '0;
      r.st = cialu_pkg::StatOk;
      case (op)
        cialu_pkg::OpAdd: begin
          r.re = RW'(longint'(ar) + longint'(br));
          r.im = RW'(longint'(ai) + longint'(bi));
        end
        cialu_pkg::OpSub: begin
          r.re = RW'(longint'(ar) - longint'(br));
          r.im = RW'(longint'(ai) - longint'(bi));
        end
        cialu_pkg::OpMul: begin
          r.re = RW'(longint'(ar) * br - longint'(ai) * bi);
          r.im = RW'(longint'(ai) * br + longint'(ar) * bi);
        end
        default: begin
          den = longint'(br) * br + longint'(bi) * bi;
          if (den == 0) begin
            r.st = cialu_pkg::StatDivZero;
          end else begin
            nre = longint'(ar) * br + longint'(ai) * bi;
            nim = longint'(ai) * br - longint'(ar) * bi;
            qre = (nre < 0) ? -((-nre) / den) : nre / den;
            qim = (nim < 0) ? -((-nim) / den) : nim / den;
            r.re = RW'(qre);
            r.im = RW'(qim);
          end
        end
      endcase
      return r;
    endfunction

    function void note_operands(cialu_pkg::op_e op, logic signed [OW-1:0] ar,
        logic signed [OW-1:0] ai, logic signed [OW-1:0] br, logic signed [OW-1:0] bi);
      pending.push_back(compute(op, ar, ai, br, bi));
    endfunction

    task check_result(cplx_res_t got);
      cplx_res_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result re=%0d im=%0d", got.re, got.im));
        return;
      end
      exp_r = pending.pop_front();
      if (got.re !== exp_r.re)
        report($sformatf("res_re got %0d exp %0d", got.re, exp_r.re));
      if (got.im !== exp_r.im)
        report($sformatf("res_im got %0d exp %0d", got.im, exp_r.im));
      if (got.st !== exp_r.st)
        report($sformatf("status got %0b exp %0b", got.st, exp_r.st));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  cialu_in_if #(.OW(OW)) in_if ();
  cialu_out_if out_if ();

  complex_integer_alu_top #(.OPERAND_WIDTH(OW)) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if.sink),
    .out_if(out_if.source)
  );

  cplx_scoreboard sb = new();
  bit quiet_phase = 1'b0;
  int idle_cycles = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.op = cialu_pkg::OpAdd;
    in_if.a_re = '0;
    in_if.a_im = '0;
    in_if.b_re = '0;
    in_if.b_im = '0;
    out_if.ready = 1'b0;
  end

  // sink side: random backpressure, none during the quiet phase
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_result('{out_if.res_re, out_if.res_im,
                          cialu_pkg::status_e'(out_if.status)});
      out_if.ready <= quiet_phase || ($urandom_range(99) >= 26);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [OW-1:0] pick_operand();
    case ($urandom_range(5))
      0: return {1'b1, {(OW-1){1'b0}}};
      1: return {1'b0, {(OW-1){1'b1}}};
      2: return '0;
      3: return OW'(int'($urandom_range(7)) - 4);
      default: return OW'($urandom);
    endcase
  endfunction

  // holds valid until the beat is taken
  task automatic send_beat(cialu_pkg::op_e op, logic [OW-1:0] ar, logic [OW-1:0] ai,
      logic [OW-1:0] br, logic [OW-1:0] bi);
    while (!quiet_phase && $urandom_range(99) < 26) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.a_re <= ar;
    in_if.a_im <= ai;
    in_if.b_re <= br;
    in_if.b_im <= bi;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_operands(op, ar, ai, br, bi);
  endtask

  localparam logic [OW-1:0] MinV = {1'b1, {(OW-1){1'b0}}};
  localparam logic [OW-1:0] MaxV = {1'b0, {(OW-1){1'b1}}};

  initial begin
    cialu_pkg::op_e op;
    int wait_cycles;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < 4; k++) begin
      op = cialu_pkg::op_e'(k);
      send_beat(op, MinV, MinV, MinV, MinV);
      send_beat(op, MaxV, MaxV, MaxV, MaxV);
      send_beat(op, MinV, MaxV, MaxV, MinV);
      send_beat(op, MaxV, MinV, MinV, MaxV);
    end
    send_beat(cialu_pkg::OpDiv, MaxV, MinV, '0, '0);
    send_beat(cialu_pkg::OpDiv, '0, '0, '0, '0);
    send_beat(cialu_pkg::OpDiv, MinV, MinV, '0, OW'(1));
    send_beat(cialu_pkg::OpDiv, OW'(7), OW'(-7), OW'(2), '0);
    send_beat(cialu_pkg::OpDiv, OW'(-7), OW'(7), '0, OW'(-2));
    send_beat(cialu_pkg::OpMul, '1, '1, '1, '1);
    for (int n = 0; n < 450; n++) begin
      quiet_phase = (n >= 150 && n < 250);
      op = cialu_pkg::op_e'($urandom_range(3));
      send_beat(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    quiet_phase = 1'b0;
    in_if.valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/cialu_pkg.sv
hw/rtl/cialu_if.sv
hw/rtl/cialu_front.sv
hw/rtl/cialu_queue.sv
hw/rtl/cialu_back.sv
hw/rtl/complex_integer_alu_top.sv
tb/complex_integer_alu_top_tb.sv
